/* hdl/dct8fi_pkg.sv */
// Shared constants, opcode codes and coefficient rounding for the 8-point DCT pipeline.
package dct8fi_pkg;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_t;

  localparam int GUARD_BITS = 8;
  localparam int NUM_LANES  = 8;

  localparam longint K_ONE   = 64'sd1073741824;
  localparam longint K_SQRT2 = 64'sd1518500250;
  localparam longint K_S8_0  = 64'sd547388835;
  localparam longint K_S8_1  = 64'sd645689156;
  localparam longint K_S8_2  = 64'sd966342111;
  localparam longint K_S8_3  = 64'sd2751909508;
  localparam longint K_S4_0  = 64'sd581104888;
  localparam longint K_S4_1  = 64'sd1402911339;

  function automatic longint cq(longint k, int e, int f);
    longint r;
    r = (k + (longint'(1) << (29 - f + e))) >>> (30 - f + e);
    return r;
  endfunction

endpackage

/* hdl/dct8_forward_inverse_top.sv */
// Top level: six-stage pipelined 8-point scaled DCT-II, forward and inverse.
// Takes one 8-sample vector per cycle with an opcode (0 forward, 1 inverse) while in_ready
// is high. Each beat passes six stage registers, and its 8 saturated values are valid on
// the outputs from the last of them. Every stage register holds one vector, so a new beat
// can enter each cycle and throughput is one vector per cycle while the output is not
// stalled; the rounding multipliers, at most eight in a stage, set the clock period.
// Ready travels back combinationally through the six stage valid bits, so a stalled output
// holds every stage that is full and fills the bubbles in front of it.
module dct8_forward_inverse_top
  import dct8fi_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int RESULT_BITS    = 20,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic signed [SAMPLE_BITS-1:0] sample_0,
  input  logic signed [SAMPLE_BITS-1:0] sample_1,
  input  logic signed [SAMPLE_BITS-1:0] sample_2,
  input  logic signed [SAMPLE_BITS-1:0] sample_3,
  input  logic signed [SAMPLE_BITS-1:0] sample_4,
  input  logic signed [SAMPLE_BITS-1:0] sample_5,
  input  logic signed [SAMPLE_BITS-1:0] sample_6,
  input  logic signed [SAMPLE_BITS-1:0] sample_7,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [RESULT_BITS-1:0] value_0,
  output logic signed [RESULT_BITS-1:0] value_1,
  output logic signed [RESULT_BITS-1:0] value_2,
  output logic signed [RESULT_BITS-1:0] value_3,
  output logic signed [RESULT_BITS-1:0] value_4,
  output logic signed [RESULT_BITS-1:0] value_5,
  output logic signed [RESULT_BITS-1:0] value_6,
  output logic signed [RESULT_BITS-1:0] value_7
);

  localparam int W  = SAMPLE_BITS + GUARD_BITS;
  localparam int CW = COEF_FRAC_BITS + 3;
  localparam int F  = COEF_FRAC_BITS;
  localparam int XW = (W > RESULT_BITS) ? W : RESULT_BITS;

  localparam logic signed [CW-1:0] C_HALF  = CW'(cq(K_ONE, 1, F));
  localparam logic signed [CW-1:0] C_QUART = CW'(cq(K_ONE, 2, F));
  localparam logic signed [CW-1:0] C_SQRT2 = CW'(cq(K_SQRT2, 0, F));
  localparam logic signed [CW-1:0] C_S8 [4] = '{
    CW'(cq(K_S8_0, 0, F)), CW'(cq(K_S8_1, 0, F)),
    CW'(cq(K_S8_2, 0, F)), CW'(cq(K_S8_3, 0, F))};
  localparam logic signed [CW-1:0] C_S8H [4] = '{
    CW'(cq(K_S8_0, 1, F)), CW'(cq(K_S8_1, 1, F)),
    CW'(cq(K_S8_2, 1, F)), CW'(cq(K_S8_3, 1, F))};
  localparam logic signed [CW-1:0] C_S4 [2] = '{
    CW'(cq(K_S4_0, 0, F)), CW'(cq(K_S4_1, 0, F))};
  localparam logic signed [CW-1:0] C_S4Q [2] = '{
    CW'(cq(K_S4_0, 2, F)), CW'(cq(K_S4_1, 2, F))};

  localparam logic signed [XW-1:0] SAT_HI =
    {{(XW-RESULT_BITS+1){1'b0}}, {(RESULT_BITS-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

  logic [6:1] vld;
  logic [6:1] rdy;
  logic [5:1] opr;

  logic signed [W-1:0] xin [NUM_LANES];
  logic signed [W-1:0] dat1 [NUM_LANES], dat1_next [NUM_LANES];
  logic signed [W-1:0] dat2 [NUM_LANES], dat2_next [NUM_LANES];
  logic signed [W-1:0] dat3 [NUM_LANES], dat3_next [NUM_LANES];
  logic signed [W-1:0] dat4 [NUM_LANES], dat4_next [NUM_LANES];
  logic signed [W-1:0] dat5 [NUM_LANES], dat5_next [NUM_LANES];
  logic signed [W-1:0] ysum [NUM_LANES];
  logic signed [XW-1:0] yext [NUM_LANES];
  logic signed [RESULT_BITS-1:0] res [NUM_LANES], res_next [NUM_LANES];

  logic signed [W-1:0]  m1x [8], m1p [8];
  logic signed [CW-1:0] m1c [8];
  logic signed [W-1:0]  m2x [8], m2p [8];
  logic signed [CW-1:0] m2c [8];
  logic signed [W-1:0]  m3x [4], m3p [4];
  logic signed [CW-1:0] m3c [4];
  logic signed [W-1:0]  m4x, m4p;
  logic signed [W-1:0]  m5x [4], m5p [4];

  // handshake: a stage advances when empty or when the next one advances
  assign rdy[6]    = !vld[6] || out_ready;
  assign rdy[5:1]  = ~vld[5:1] | rdy[6:2];
  assign in_ready  = rdy[1];
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      opr[1] <= opcode;
      dat1   <= dat1_next;
    end
    if (rdy[2]) begin
      opr[2] <= opr[1];
      dat2   <= dat2_next;
    end
    if (rdy[3]) begin
      opr[3] <= opr[2];
      dat3   <= dat3_next;
    end
    if (rdy[4]) begin
      opr[4] <= opr[3];
      dat4   <= dat4_next;
    end
    if (rdy[5]) begin
      opr[5] <= opr[4];
      dat5   <= dat5_next;
    end
    if (rdy[6]) begin
      res <= res_next;
    end
  end

  assign xin[0] = {{GUARD_BITS{sample_0[SAMPLE_BITS-1]}}, sample_0};
  assign xin[1] = {{GUARD_BITS{sample_1[SAMPLE_BITS-1]}}, sample_1};
  assign xin[2] = {{GUARD_BITS{sample_2[SAMPLE_BITS-1]}}, sample_2};
  assign xin[3] = {{GUARD_BITS{sample_3[SAMPLE_BITS-1]}}, sample_3};
  assign xin[4] = {{GUARD_BITS{sample_4[SAMPLE_BITS-1]}}, sample_4};
  assign xin[5] = {{GUARD_BITS{sample_5[SAMPLE_BITS-1]}}, sample_5};
  assign xin[6] = {{GUARD_BITS{sample_6[SAMPLE_BITS-1]}}, sample_6};
  assign xin[7] = {{GUARD_BITS{sample_7[SAMPLE_BITS-1]}}, sample_7};

  // stage 1: mirror sums and differences with secant scaling, or inverse even/odd split and neighbor sums
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m1x[i]   = xin[i] + xin[7-i];
      m1c[i]   = C_HALF;
      m1x[4+i] = xin[i] - xin[7-i];
      m1c[4+i] = C_S8H[i];
    end
    if (opcode == OP_INV) begin
      m1x[4] = xin[1];
      m1c[4] = C_SQRT2;
    end
  end

  always_comb begin
    if (opcode == OP_INV) begin
      dat1_next[0] = xin[0];
      dat1_next[1] = xin[2];
      dat1_next[2] = xin[4];
      dat1_next[3] = xin[6];
      dat1_next[4] = m1p[4];
      dat1_next[5] = xin[3] + xin[1];
      dat1_next[6] = xin[5] + xin[3];
      dat1_next[7] = xin[7] + xin[5];
    end else begin
      dat1_next = m1p;
    end
  end

  // stage 2: first products of the two 4-point halves, with even butterflies in inverse mode
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      m2x[4*h]   = (dat1[4*h] + dat1[4*h+3]) + (dat1[4*h+1] + dat1[4*h+2]);
      m2c[4*h]   = C_QUART;
      m2x[4*h+2] = (dat1[4*h] + dat1[4*h+3]) - (dat1[4*h+1] + dat1[4*h+2]);
      m2c[4*h+2] = C_QUART;
      m2x[4*h+3] = dat1[4*h+1] - dat1[4*h+2];
      m2c[4*h+3] = C_S4Q[1];
      if (opr[1] == OP_INV) begin
        m2x[4*h+1] = dat1[4*h+1];
        m2c[4*h+1] = C_SQRT2;
      end else begin
        m2x[4*h+1] = dat1[4*h] - dat1[4*h+3];
        m2c[4*h+1] = C_S4Q[0];
      end
    end
  end

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      if (opr[1] == OP_INV) begin
        dat2_next[4*h]   = dat1[4*h] + dat1[4*h+2];
        dat2_next[4*h+1] = m2p[4*h+1];
        dat2_next[4*h+2] = dat1[4*h] - dat1[4*h+2];
        dat2_next[4*h+3] = dat1[4*h+1] + dat1[4*h+3];
      end else begin
        dat2_next[4*h]   = m2p[4*h];
        dat2_next[4*h+1] = m2p[4*h+1];
        dat2_next[4*h+2] = m2p[4*h+2];
        dat2_next[4*h+3] = m2p[4*h+3];
      end
    end
  end

  // stage 3: rotation products
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      m3x[2*h]   = dat2[4*h+1] + dat2[4*h+3];
      m3c[2*h]   = (opr[2] == OP_INV) ? C_S4[0] : C_SQRT2;
      m3x[2*h+1] = dat2[4*h+1] - dat2[4*h+3];
      m3c[2*h+1] = C_S4[1];
    end
  end

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      dat3_next[4*h]   = dat2[4*h];
      dat3_next[4*h+2] = dat2[4*h+2];
      if (opr[2] == OP_INV) begin
        dat3_next[4*h+1] = m3p[2*h];
        dat3_next[4*h+3] = m3p[2*h+1];
      end else begin
        dat3_next[4*h+1] = m3p[2*h] + (dat2[4*h+1] - dat2[4*h+3]);
        dat3_next[4*h+3] = dat2[4*h+1] - dat2[4*h+3];
      end
    end
  end

  // stage 4: odd DC scaling or inverse half recombination
  assign m4x = dat3[4];

  always_comb begin
    if (opr[3] == OP_INV) begin
      for (int h = 0; h < 2; h++) begin
        dat4_next[4*h]   = dat3[4*h] + dat3[4*h+1];
        dat4_next[4*h+1] = dat3[4*h+2] + dat3[4*h+3];
        dat4_next[4*h+2] = dat3[4*h+2] - dat3[4*h+3];
        dat4_next[4*h+3] = dat3[4*h] - dat3[4*h+1];
      end
    end else begin
      dat4_next    = dat3;
      dat4_next[4] = m4p;
    end
  end

  // stage 5: neighbor sums or output secant scaling
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m5x[i] = dat4[4+i];
    end
  end

  always_comb begin
    if (opr[4] == OP_INV) begin
      for (int i = 0; i < 4; i++) begin
        dat5_next[i]   = dat4[i];
        dat5_next[4+i] = m5p[i];
      end
    end else begin
      dat5_next[0] = dat4[0];
      dat5_next[1] = dat4[4] + dat4[5];
      dat5_next[2] = dat4[1];
      dat5_next[3] = dat4[5] + dat4[6];
      dat5_next[4] = dat4[2];
      dat5_next[5] = dat4[6] + dat4[7];
      dat5_next[6] = dat4[3];
      dat5_next[7] = dat4[7];
    end
  end

  // stage 6: final butterfly in inverse mode, and saturation
  always_comb begin
    if (opr[5] == OP_INV) begin
      for (int i = 0; i < 4; i++) begin
        ysum[i]   = dat5[i] + dat5[4+i];
        ysum[7-i] = dat5[i] - dat5[4+i];
      end
    end else begin
      ysum = dat5;
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      yext[i] = XW'(ysum[i]);
      if (yext[i] > SAT_HI) begin
        res_next[i] = RESULT_BITS'(SAT_HI);
      end else if (yext[i] < SAT_LO) begin
        res_next[i] = RESULT_BITS'(SAT_LO);
      end else begin
        res_next[i] = RESULT_BITS'(yext[i]);
      end
    end
  end

  assign value_0 = res[0];
  assign value_1 = res[1];
  assign value_2 = res[2];
  assign value_3 = res[3];
  assign value_4 = res[4];
  assign value_5 = res[5];
  assign value_6 = res[6];
  assign value_7 = res[7];

  for (genvar g = 0; g < 8; g++) begin : g_m12
    dct8fi_rmul #(.DW(W), .CW(CW), .F(F)) u_m1 (.x(m1x[g]), .c(m1c[g]), .y(m1p[g]));
    dct8fi_rmul #(.DW(W), .CW(CW), .F(F)) u_m2 (.x(m2x[g]), .c(m2c[g]), .y(m2p[g]));
  end

  for (genvar g = 0; g < 4; g++) begin : g_m35
    dct8fi_rmul #(.DW(W), .CW(CW), .F(F)) u_m3 (.x(m3x[g]), .c(m3c[g]), .y(m3p[g]));
    dct8fi_rmul #(.DW(W), .CW(CW), .F(F)) u_m5 (.x(m5x[g]), .c(C_S8[g]), .y(m5p[g]));
  end

  dct8fi_rmul #(.DW(W), .CW(CW), .F(F)) u_m4 (.x(m4x), .c(C_SQRT2), .y(m4p));

`ifndef ASSERT_OFF
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[1])
    else $error("accepted beat did not reach stage 1");

  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !rdy[3] |=> vld[3] && $stable(opr[3]))
    else $error("stalled stage 3 lost or changed its beat");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !vld[5] |=> !out_valid)
    else $error("output beat repeated");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    vld[6] && vld[5] && !out_ready |=> vld[6] && vld[5])
    else $error("output stall did not hold the pipeline");
`endif

endmodule

/* hdl/dct8fi_rmul.sv */
// Signed multiply by a fixed-point coefficient, rounded to nearest with halves up.
module dct8fi_rmul
  import dct8fi_pkg::*;
#(
  parameter int DW = 24,
  parameter int CW = 17,
  parameter int F  = 14
) (
  input  logic signed [DW-1:0] x,
  input  logic signed [CW-1:0] c,
  output logic signed [DW-1:0] y
);

  localparam int PW = DW + CW;
  localparam logic signed [PW-1:0] RND = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;

  assign prod = PW'(x) * PW'(c);
  assign sum  = prod + RND;
  assign y    = signed'(sum[F +: DW]);

endmodule

/* tb/sv/dct8fi_tb_pkg.sv */
// Vector types, Q30 transform constants and the scoreboard for the 8-point DCT testbench.
package dct8fi_tb_pkg;
  import dct8fi_pkg::*;

  localparam int SAMPLE_W  = 16;
  localparam int RESULT_W  = 20;
  localparam int COEF_FRAC = 14;
  localparam int LANES     = 8;

  localparam longint Q30_ONE   = 64'sd1073741824;
  localparam longint Q30_ROOT2 = 64'sd1518500250;
  localparam longint Q30_SEC8_0 = 64'sd547388835;
  localparam longint Q30_SEC8_1 = 64'sd645689156;
  localparam longint Q30_SEC8_2 = 64'sd966342111;
  localparam longint Q30_SEC8_3 = 64'sd2751909508;
  localparam longint Q30_SEC4_0 = 64'sd581104888;
  localparam longint Q30_SEC4_1 = 64'sd1402911339;

  typedef logic [LANES-1:0][SAMPLE_W-1:0] sample_vec_t;
  typedef logic [LANES-1:0][RESULT_W-1:0] result_vec_t;

  class dct8_scoreboard;
    result_vec_t expected_vectors[$];
    int failures;
    longint c_root2, c_half, c_quarter;
    longint c_sec8[4], c_sec8_half[4], c_sec4[2], c_sec4_quarter[2];

    function new();
      longint sec8_q30[4];
      sec8_q30 = '{Q30_SEC8_0, Q30_SEC8_1, Q30_SEC8_2, Q30_SEC8_3};
      failures = 0;
      c_root2 = round_coef(Q30_ROOT2, 0);
      c_half = round_coef(Q30_ONE, 1);
      c_quarter = round_coef(Q30_ONE, 2);
      for (int i = 0; i < 4; i++) begin
        c_sec8[i] = round_coef(sec8_q30[i], 0);
        c_sec8_half[i] = round_coef(sec8_q30[i], 1);
      end
      c_sec4[0] = round_coef(Q30_SEC4_0, 0);
      c_sec4[1] = round_coef(Q30_SEC4_1, 0);
      c_sec4_quarter[0] = round_coef(Q30_SEC4_0, 2);
      c_sec4_quarter[1] = round_coef(Q30_SEC4_1, 2);
    endfunction

    function longint round_coef(longint k, int e);
      return (k + (longint'(1) <<< (29 - COEF_FRAC + e))) >>> (30 - COEF_FRAC + e);
    endfunction

    // round half up, dropping the 14 fraction bits of the coefficient
    function longint scale(longint x, longint c);
      return (x * c + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function logic [RESULT_W-1:0] clamp(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (RESULT_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return RESULT_W'(v);
    endfunction

    function void half_forward(input longint v[4], output longint o[4]);
      longint s03, s12, t0, t1, m;
      s03 = v[0] + v[3];
      s12 = v[1] + v[2];
      t0 = scale(v[0] - v[3], c_sec4_quarter[0]);
      t1 = scale(v[1] - v[2], c_sec4_quarter[1]);
      m = t0 - t1;
      o[0] = scale(s03 + s12, c_quarter);
      o[1] = scale(t0 + t1, c_root2) + m;
      o[2] = scale(s03 - s12, c_quarter);
      o[3] = m;
    endfunction

    function void half_inverse(input longint v[4], output longint o[4]);
      longint t0, t1, q0, q1, s, d;
      t0 = scale(v[1], c_root2);
      t1 = v[1] + v[3];
      q0 = scale(t0 + t1, c_sec4[0]);
      q1 = scale(t0 - t1, c_sec4[1]);
      s = v[0] + v[2];
      d = v[0] - v[2];
      o[0] = s + q0;
      o[1] = d + q1;
      o[2] = d - q1;
      o[3] = s - q0;
    endfunction

    function result_vec_t predict_transform(op_t op, sample_vec_t samples);
      longint x[8], y[8], a[4], b[4], e[4], o[4];
      longint r;
      result_vec_t res;
      for (int i = 0; i < LANES; i++) x[i] = longint'($signed(samples[i]));
      if (op == OP_FWD) begin
        for (int i = 0; i < 4; i++) begin
          a[i] = scale(x[i] + x[7-i], c_half);
          b[i] = scale(x[i] - x[7-i], c_sec8_half[i]);
        end
        half_forward(a, e);
        half_forward(b, o);
        y[0] = e[0];
        y[2] = e[1];
        y[4] = e[2];
        y[6] = e[3];
        o[0] = scale(o[0], c_root2);
        y[1] = o[0] + o[1];
        y[3] = o[1] + o[2];
        y[5] = o[2] + o[3];
        y[7] = o[3];
      end else begin
        a[0] = x[0];
        a[1] = x[2];
        a[2] = x[4];
        a[3] = x[6];
        b[0] = scale(x[1], c_root2);
        b[1] = x[3] + x[1];
        b[2] = x[5] + x[3];
        b[3] = x[7] + x[5];
        half_inverse(a, e);
        half_inverse(b, o);
        for (int i = 0; i < 4; i++) begin
          r = scale(o[i], c_sec8[i]);
          y[i] = e[i] + r;
          y[7-i] = e[i] - r;
        end
      end
      for (int i = 0; i < LANES; i++) res[i] = clamp(y[i]);
      return res;
    endfunction

    function void note_input(op_t op, sample_vec_t samples);
      expected_vectors.push_back(predict_transform(op, samples));
    endfunction

    function void check_result(result_vec_t got);
      result_vec_t want;
      if (expected_vectors.size() == 0) begin
        if (failures < 10) $display("result beat with no pending vector");
        failures++;
        return;
      end
      want = expected_vectors.pop_front();
      for (int i = 0; i < LANES; i++) begin
        if (got[i] !== want[i]) begin
          if (failures < 10)
            $display("value_%0d mismatch: expected %0d, got %0d", i,
                     $signed(want[i]), $signed(got[i]));
          failures++;
        end
      end
    endfunction

    function int outstanding();
      return expected_vectors.size();
    endfunction
  endclass

endpackage

/* tb/sv/dct8_forward_inverse_top_tb.sv */
// Top-level testbench: random and directed vectors through the 8-point DCT with a scoreboard.
module dct8_forward_inverse_top_tb
  import dct8fi_pkg::*;
  import dct8fi_tb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_ITEMS  = 100;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
  logic signed [SAMPLE_W-1:0] sample_4 = '0, sample_5 = '0, sample_6 = '0, sample_7 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RESULT_W-1:0] value_0, value_1, value_2, value_3;
  logic signed [RESULT_W-1:0] value_4, value_5, value_6, value_7;

  bit tail_phase = 1'b0;
  dct8_scoreboard sb = new;

  dct8_forward_inverse_top #(
    .SAMPLE_BITS(SAMPLE_W),
    .RESULT_BITS(RESULT_W),
    .COEF_FRAC_BITS(COEF_FRAC)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
    .sample_4(sample_4), .sample_5(sample_5), .sample_6(sample_6), .sample_7(sample_7),
    .out_valid(out_valid), .out_ready(out_ready),
    .value_0(value_0), .value_1(value_1), .value_2(value_2), .value_3(value_3),
    .value_4(value_4), .value_5(value_5), .value_6(value_6), .value_7(value_7)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sample_vec_t directed_samples(int pattern);
    sample_vec_t s;
    for (int i = 0; i < LANES; i++) begin
      case (pattern)
        0: s[i] = '0;
        1: s[i] = SAMPLE_MAX;
        2: s[i] = SAMPLE_MIN;
        3: s[i] = (i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
        4: s[i] = (i % 2 == 0) ? SAMPLE_MIN : SAMPLE_MAX;
        5: s[i] = (i == 0) ? SAMPLE_MAX : '0;
        6: s[i] = (i == 7) ? SAMPLE_MIN : '0;
        7: s[i] = SAMPLE_W'(i * 9000 - 32000);
        8: s[i] = ((i / 2) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
        9: s[i] = (i == 1 || i == 2 || i == 5 || i == 6) ? SAMPLE_MIN : SAMPLE_MAX;
        10: s[i] = '1;
        default: s[i] = SAMPLE_W'(1);
      endcase
    end
    return s;
  endfunction

  function automatic sample_vec_t random_samples();
    sample_vec_t s;
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < LANES; i++) begin
      case (kind)
        0: s[i] = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        1: s[i] = SAMPLE_W'($urandom_range(0, 127) - 64);
        default: s[i] = SAMPLE_W'($urandom);
      endcase
    end
    return s;
  endfunction

  task automatic send_vector(input op_t op, input sample_vec_t s);
    in_valid <= 1'b1;
    opcode <= op;
    sample_0 <= s[0];
    sample_1 <= s[1];
    sample_2 <= s[2];
    sample_3 <= s[3];
    sample_4 <= s[4];
    sample_5 <= s[5];
    sample_6 <= s[6];
    sample_7 <= s[7];
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, s);
  endtask

  task automatic maybe_idle();
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < 24; k++) begin
      send_vector(op_t'(k % 2), directed_samples(k / 2));
      maybe_idle();
    end
    wait_for_drain();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      tail_phase = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      send_vector(op_t'($urandom_range(0, 1)), random_samples());
      maybe_idle();
    end
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_valid && out_ready)
        sb.check_result({value_7, value_6, value_5, value_4,
                         value_3, value_2, value_1, value_0});
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
